// File: design/servo_keyframe_sequencer_assert.svh
// assertion macros shared by the servo keyframe sequencer
`ifndef SERVO_KEYFRAME_SEQUENCER_ASSERT_SVH
`define SERVO_KEYFRAME_SEQUENCER_ASSERT_SVH

// property checked at every edge outside reset
`define SKF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// consequence in the cycle after the trigger
`define SKF_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: design/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg
// Types and constants shared by the servo keyframe sequencer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package skf_pkg;

  localparam int unsigned FUNC_W    = 3;
  localparam int unsigned GID_W     = 4;
  localparam int unsigned POS_W     = 12;
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned LOOP_W    = 16;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned TOTAL_W   = 5;
  localparam int unsigned POS_PORTS = 6;

  localparam logic [TIME_W-1:0] DEF_MOVE_TIME = 16'd500;

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK      = 3'd0,
    FN_PLAY      = 3'd1,
    FN_STOP      = 3'd2,
    FN_REC_START = 3'd3,
    FN_REC_FRAME = 3'd4,
    FN_SAVE      = 3'd5,
    FN_DELETE    = 3'd6
  } func_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE = 2'd0,
    MODE_PLAY = 2'd1,
    MODE_REC  = 2'd2,
    MODE_STOP = 2'd3
  } mode_e;

  // per-transaction result flags, decided at accept
  typedef struct packed {
    logic status;
    logic drive;
    logic stop;
  } rsp_info_t;

endpackage

// File: design/skf_frame_mem.sv
// ----------------------------------------------------------------------------
// skf_frame_mem
// Keyframe store: one row per frame holds move time and all servo positions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skf_frame_mem #(
  parameter int unsigned AW = 10,
  parameter int unsigned DW = 88
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  localparam int unsigned DEPTH = 1 << AW;

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/skf_seq_core.sv
// ----------------------------------------------------------------------------
// skf_seq_core
// Sequencer state, group tables and per-operation decode; issues frame
// memory reads and writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skf_seq_core #(
  parameter int unsigned GROUPS = 16,
  parameter int unsigned FRAMES = 64,
  parameter int unsigned SERVOS = 6,
  parameter int unsigned GW     = 4,
  parameter int unsigned FW     = 6,
  parameter int unsigned DW     = 88
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             acc_i,
  input  logic [skf_pkg::FUNC_W-1:0]       func_i,
  input  logic [skf_pkg::GID_W-1:0]        gid_i,
  input  logic [skf_pkg::LOOP_W-1:0]       lc_i,
  input  logic [skf_pkg::POS_W-1:0]        pos_i [skf_pkg::POS_PORTS],
  input  logic                             cfg_we_i,
  input  logic [skf_pkg::TIME_W-1:0]       cfg_wdata_i,
  input  logic [skf_pkg::TIME_W-1:0]       rd_time_i,
  output logic                             mem_we_o,
  output logic [GW+FW-1:0]                 mem_waddr_o,
  output logic [DW-1:0]                    mem_wdata_o,
  output logic                             mem_re_o,
  output logic [GW+FW-1:0]                 mem_raddr_o,
  output skf_pkg::rsp_info_t               info_o,
  output logic [skf_pkg::MODE_W-1:0]       mode_o,
  output logic [skf_pkg::TOTAL_W-1:0]      total_o
);

  import skf_pkg::*;

  localparam int unsigned CW  = $clog2(FRAMES + 1);
  localparam int unsigned SGW = $clog2(GROUPS + 1);

  logic [CW-1:0]     fc_q [GROUPS];
  logic [LOOP_W-1:0] lt_q [GROUPS];

  mode_e              mode_q, mode_d;
  logic [GW-1:0]      act_q, act_d;
  logic [GW-1:0]      rec_q, rec_d;
  logic [CW-1:0]      fi_q, fi_d;
  logic [LOOP_W-1:0]  loops_q, loops_d;
  logic [TIME_W-1:0]  el_q, el_d;
  logic [SGW-1:0]     stored_q, stored_d;
  logic [TIME_W-1:0]  dmt_q;
  logic [TIME_W-1:0]  cur_time_q;
  logic               send_q;
  rsp_info_t          info_q, info_d;

  logic              gid_ok;
  logic [GW-1:0]     gid_idx;
  logic [GW-1:0]     rd_idx;
  logic [CW-1:0]     fc_rd;
  logic [CW-1:0]     fi_inc;
  logic [TIME_W-1:0] el_inc;
  logic              fc_we, lt_we, mem_we, mem_re;
  logic [GW-1:0]     tab_idx;
  logic [CW-1:0]     fc_wval;
  logic [LOOP_W-1:0] lt_wval;
  logic [GW+FW-1:0]  raddr;
  logic              last_pass;

  assign gid_ok  = {1'b0, gid_i} < TOTAL_W'(GROUPS);
  assign gid_idx = gid_i[GW-1:0];
  assign fi_inc  = fi_q + CW'(1);
  assign el_inc  = (el_q == '1) ? el_q : el_q + TIME_W'(1);

  always_comb begin
    unique case (func_e'(func_i))
      FN_TICK: rd_idx = act_q;
      FN_SAVE: rd_idx = rec_q;
      default: rd_idx = gid_idx;
    endcase
  end

  assign fc_rd = fc_q[rd_idx];

  always_comb begin
    info_d    = '0;
    mode_d    = mode_q;
    act_d     = act_q;
    rec_d     = rec_q;
    fi_d      = fi_q;
    loops_d   = loops_q;
    el_d      = el_q;
    stored_d  = stored_q;
    fc_we     = 1'b0;
    lt_we     = 1'b0;
    fc_wval   = '0;
    lt_wval   = '0;
    tab_idx   = gid_idx;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    raddr     = {act_q, fi_q[FW-1:0]};
    last_pass = 1'b0;
    unique case (func_e'(func_i))
      FN_TICK: begin
        if (mode_q == MODE_PLAY) begin
          el_d = el_inc;
          if (el_inc >= cur_time_q) begin
            fi_d = fi_inc;
            if (fi_inc >= fc_rd) begin
              if (loops_q == '0) begin
                fi_d = '0;
              end else if (loops_q > LOOP_W'(1)) begin
                loops_d = loops_q - LOOP_W'(1);
                fi_d    = '0;
              end else begin
                last_pass = 1'b1;
                mode_d    = MODE_IDLE;
              end
            end
            if (!last_pass) begin
              info_d.drive = 1'b1;
              mem_re       = 1'b1;
              raddr        = {act_q, fi_d[FW-1:0]};
              el_d         = '0;
            end
          end
        end
      end
      FN_PLAY: begin
        if (!gid_ok || fc_rd == '0) begin
          info_d.status = 1'b1;
        end else begin
          info_d.stop  = (mode_q == MODE_PLAY);
          info_d.drive = 1'b1;
          act_d        = gid_idx;
          fi_d         = '0;
          loops_d      = lt_q[gid_idx];
          mode_d       = MODE_PLAY;
          el_d         = '0;
          mem_re       = 1'b1;
          raddr        = {gid_idx, FW'(0)};
        end
      end
      FN_STOP: begin
        mode_d      = MODE_STOP;
        info_d.stop = 1'b1;
      end
      FN_REC_START: begin
        if (!gid_ok) begin
          info_d.status = 1'b1;
        end else begin
          fc_we   = 1'b1;
          lt_we   = 1'b1;
          lt_wval = lc_i;
          rec_d   = gid_idx;
          fi_d    = '0;
          mode_d  = MODE_REC;
        end
      end
      FN_REC_FRAME: begin
        if (mode_q != MODE_REC || fi_q >= CW'(FRAMES)) begin
          info_d.status = 1'b1;
        end else begin
          mem_we  = 1'b1;
          fi_d    = fi_inc;
          fc_we   = 1'b1;
          fc_wval = fi_inc;
          tab_idx = rec_q;
        end
      end
      FN_SAVE: begin
        if (mode_q != MODE_REC || fc_rd == '0) begin
          info_d.status = 1'b1;
        end else begin
          if (TOTAL_W'(rec_q) >= TOTAL_W'(stored_q)) begin
            stored_d = SGW'(rec_q) + SGW'(1);
          end
          mode_d = MODE_IDLE;
        end
      end
      FN_DELETE: begin
        if (!gid_ok) begin
          info_d.status = 1'b1;
        end else begin
          fc_we   = 1'b1;
          lt_we   = 1'b1;
          lt_wval = LOOP_W'(1);
          if ({1'b0, gid_i} < TOTAL_W'(stored_q)) begin
            stored_d = stored_q - SGW'(1);
          end
        end
      end
      default: begin
        info_d.status = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      act_q    <= '0;
      rec_q    <= '0;
      fi_q     <= '0;
      loops_q  <= '0;
      el_q     <= '0;
      stored_q <= '0;
      info_q   <= '0;
      send_q   <= 1'b0;
      for (int g = 0; g < GROUPS; g++) begin
        fc_q[g] <= '0;
        lt_q[g] <= LOOP_W'(1);
      end
    end else begin
      send_q <= acc_i && mem_re;
      if (acc_i) begin
        mode_q   <= mode_d;
        act_q    <= act_d;
        rec_q    <= rec_d;
        fi_q     <= fi_d;
        loops_q  <= loops_d;
        el_q     <= el_d;
        stored_q <= stored_d;
        info_q   <= info_d;
        if (fc_we) begin
          fc_q[tab_idx] <= fc_wval;
        end
        if (lt_we) begin
          lt_q[tab_idx] <= lt_wval;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dmt_q <= DEF_MOVE_TIME;
    end else if (cfg_we_i) begin
      dmt_q <= cfg_wdata_i;
    end
  end

  // time of the frame just sent, compared by later ticks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_time_q <= '0;
    end else if (send_q) begin
      cur_time_q <= rd_time_i;
    end
  end

  for (genvar s = 0; s < SERVOS; s++) begin : g_wpos
    assign mem_wdata_o[s*POS_W +: POS_W] = pos_i[s];
  end
  assign mem_wdata_o[SERVOS*POS_W +: TIME_W] = dmt_q;

  assign mem_we_o    = acc_i && mem_we;
  assign mem_re_o    = acc_i && mem_re;
  assign mem_waddr_o = {rec_q, fi_q[FW-1:0]};
  assign mem_raddr_o = raddr;
  assign info_o      = info_q;
  assign mode_o      = mode_q;
  assign total_o     = TOTAL_W'(stored_q);

endmodule

// File: design/servo_keyframe_sequencer.sv
// ----------------------------------------------------------------------------
// servo_keyframe_sequencer
// Response: an accepted transaction waits in the response state for the frame
// memory read (address at accept, registered data) and for the previous result to
// leave; input stalls until its result is loaded.
// Reset: group tables and control state clear at once; frame memory is not
// cleared and needs no clearing pass, the block takes input right after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module servo_keyframe_sequencer #(
  parameter int unsigned GROUPS = 16,
  parameter int unsigned FRAMES = 64,
  parameter int unsigned SERVOS = 6
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [skf_pkg::TIME_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [skf_pkg::FUNC_W-1:0]     func_i,
  input  logic [skf_pkg::GID_W-1:0]      group_id_i,
  input  logic [skf_pkg::LOOP_W-1:0]     loop_count_i,
  input  logic [skf_pkg::POS_W-1:0]      pos_0_i,
  input  logic [skf_pkg::POS_W-1:0]      pos_1_i,
  input  logic [skf_pkg::POS_W-1:0]      pos_2_i,
  input  logic [skf_pkg::POS_W-1:0]      pos_3_i,
  input  logic [skf_pkg::POS_W-1:0]      pos_4_i,
  input  logic [skf_pkg::POS_W-1:0]      pos_5_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           status_o,
  output logic                           drive_valid_o,
  output logic                           stop_servos_o,
  output logic [skf_pkg::POS_W-1:0]      out_pos_0_o,
  output logic [skf_pkg::POS_W-1:0]      out_pos_1_o,
  output logic [skf_pkg::POS_W-1:0]      out_pos_2_o,
  output logic [skf_pkg::POS_W-1:0]      out_pos_3_o,
  output logic [skf_pkg::POS_W-1:0]      out_pos_4_o,
  output logic [skf_pkg::POS_W-1:0]      out_pos_5_o,
  output logic [skf_pkg::TIME_W-1:0]     move_time_o,
  output logic [skf_pkg::MODE_W-1:0]     mode_o,
  output logic [skf_pkg::TOTAL_W-1:0]    group_total_o
);

  import skf_pkg::*;

  `include "servo_keyframe_sequencer_assert.svh"

  localparam int unsigned GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int unsigned FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned AW = GW + FW;
  localparam int unsigned DW = SERVOS * POS_W + TIME_W;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_e;

  state_e state_q;

  logic                  in_acc;
  logic [POS_W-1:0]      in_pos [POS_PORTS];
  logic [POS_W-1:0]      rd_pos [POS_PORTS];
  logic [TIME_W-1:0]     rd_time;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [DW-1:0]         mem_wdata, mem_rdata;
  rsp_info_t             info;
  logic [MODE_W-1:0]     core_mode;
  logic [TOTAL_W-1:0]    core_total;
  logic                  resp_load;

  logic                  out_valid_q;
  logic                  status_q, drive_q, stop_q;
  logic [POS_W-1:0]      pos_q [POS_PORTS];
  logic [TIME_W-1:0]     time_q;
  logic [MODE_W-1:0]     mode_q;
  logic [TOTAL_W-1:0]    total_q;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign resp_load  = (state_q == S_RESP) && (!out_valid_q || !out_stall_i);

  assign in_pos[0] = pos_0_i;
  assign in_pos[1] = pos_1_i;
  assign in_pos[2] = pos_2_i;
  assign in_pos[3] = pos_3_i;
  assign in_pos[4] = pos_4_i;
  assign in_pos[5] = pos_5_i;

  skf_seq_core #(
    .GROUPS (GROUPS),
    .FRAMES (FRAMES),
    .SERVOS (SERVOS),
    .GW     (GW),
    .FW     (FW),
    .DW     (DW)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (in_acc),
    .func_i      (func_i),
    .gid_i       (group_id_i),
    .lc_i        (loop_count_i),
    .pos_i       (in_pos),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rd_time_i   (rd_time),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .info_o      (info),
    .mode_o      (core_mode),
    .total_o     (core_total)
  );

  skf_frame_mem #(
    .AW (AW),
    .DW (DW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  for (genvar s = 0; s < POS_PORTS; s++) begin : g_rpos
    if (s < SERVOS) begin : g_used
      assign rd_pos[s] = mem_rdata[s*POS_W +: POS_W];
    end else begin : g_unused
      assign rd_pos[s] = '0;
    end
  end
  assign rd_time = mem_rdata[SERVOS*POS_W +: TIME_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      status_q    <= 1'b0;
      drive_q     <= 1'b0;
      stop_q      <= 1'b0;
      time_q      <= '0;
      mode_q      <= '0;
      total_q     <= '0;
      for (int s = 0; s < POS_PORTS; s++) begin
        pos_q[s] <= '0;
      end
    end else begin
      if (resp_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          // load only once the previous result has left
          if (resp_load) begin
            status_q    <= info.status;
            drive_q     <= info.drive;
            stop_q      <= info.stop;
            time_q      <= info.drive ? rd_time : '0;
            mode_q      <= core_mode;
            total_q     <= core_total;
            for (int s = 0; s < POS_PORTS; s++) begin
              pos_q[s] <= info.drive ? rd_pos[s] : '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign drive_valid_o = drive_q;
  assign stop_servos_o = stop_q;
  assign out_pos_0_o   = pos_q[0];
  assign out_pos_1_o   = pos_q[1];
  assign out_pos_2_o   = pos_q[2];
  assign out_pos_3_o   = pos_q[3];
  assign out_pos_4_o   = pos_q[4];
  assign out_pos_5_o   = pos_q[5];
  assign move_time_o   = time_q;
  assign mode_o        = mode_q;
  assign group_total_o = total_q;

  `SKF_ASSERT_NEXT(a_accept_to_resp, in_acc, state_q == S_RESP,
                   "accepted transaction did not move to response")
  `SKF_ASSERT(a_drive_not_refused, !(out_valid_o && status_o && drive_valid_o),
              "refused transaction drives a frame")
  `SKF_ASSERT(a_drive_while_playing, (out_valid_o && drive_valid_o) |-> (mode_o == MODE_PLAY),
              "frame sent outside playback")
  `SKF_ASSERT(a_total_bound, group_total_o <= TOTAL_W'(GROUPS),
              "stored group count beyond group capacity")

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the servo keyframe sequencer. Operations go in one at a time
// over the valid/stall input channel. A predictor of the group tables, the
// frame store and the player works out each expected servo command. Results
// are checked field by field in order, with random gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import skf_pkg::*;

  localparam int unsigned NUM_GROUPS   = 16;
  localparam int unsigned NUM_FRAMES   = 64;
  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;
  localparam int unsigned RANDOM_OPS   = 1500;
  localparam int unsigned IDLE_LIMIT   = 1000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PRINT_LIMIT  = 50;

  typedef struct packed {
    logic [FUNC_W-1:0]               func;
    logic [GID_W-1:0]                gid;
    logic [LOOP_W-1:0]               loops;
    logic [POS_PORTS-1:0][POS_W-1:0] pos;
  } seq_op_t;

  typedef struct packed {
    logic                            status;
    logic                            drive;
    logic                            stop;
    logic [POS_PORTS-1:0][POS_W-1:0] pos;
    logic [TIME_W-1:0]               mtime;
    logic [MODE_W-1:0]               mode;
    logic [TOTAL_W-1:0]              total;
  } servo_cmd_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [TIME_W-1:0]   cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [FUNC_W-1:0]   func_i;
  logic [GID_W-1:0]    group_id_i;
  logic [LOOP_W-1:0]   loop_count_i;
  logic [POS_W-1:0]    pos_0_i, pos_1_i, pos_2_i, pos_3_i, pos_4_i, pos_5_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                status_o;
  logic                drive_valid_o;
  logic                stop_servos_o;
  logic [POS_W-1:0]    out_pos_0_o, out_pos_1_o, out_pos_2_o;
  logic [POS_W-1:0]    out_pos_3_o, out_pos_4_o, out_pos_5_o;
  logic [TIME_W-1:0]   move_time_o;
  logic [MODE_W-1:0]   mode_o;
  logic [TOTAL_W-1:0]  group_total_o;

  // predictor state
  logic [POS_W-1:0]    kf_pos [NUM_GROUPS][NUM_FRAMES][POS_PORTS];
  logic [TIME_W-1:0]   kf_time [NUM_GROUPS][NUM_FRAMES];
  logic [6:0]          grp_frames [NUM_GROUPS];
  logic [LOOP_W-1:0]   grp_loops [NUM_GROUPS];
  mode_e               cur_mode;
  logic [GID_W-1:0]    play_grp;
  logic [6:0]          cur_frame;
  logic [LOOP_W-1:0]   passes_left;
  logic [TIME_W-1:0]   elapsed;
  logic [GID_W-1:0]    rec_grp;
  logic [TOTAL_W-1:0]  saved_groups;
  logic [TIME_W-1:0]   move_time_reg;

  servo_cmd_t          pending_cmds[$];
  int unsigned         mismatches;
  int unsigned         ops_sent;
  int unsigned         idle_cycles;
  logic                quiet;

  servo_keyframe_sequencer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .func_i        (func_i),
    .group_id_i    (group_id_i),
    .loop_count_i  (loop_count_i),
    .pos_0_i       (pos_0_i),
    .pos_1_i       (pos_1_i),
    .pos_2_i       (pos_2_i),
    .pos_3_i       (pos_3_i),
    .pos_4_i       (pos_4_i),
    .pos_5_i       (pos_5_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .drive_valid_o (drive_valid_o),
    .stop_servos_o (stop_servos_o),
    .out_pos_0_o   (out_pos_0_o),
    .out_pos_1_o   (out_pos_1_o),
    .out_pos_2_o   (out_pos_2_o),
    .out_pos_3_o   (out_pos_3_o),
    .out_pos_4_o   (out_pos_4_o),
    .out_pos_5_o   (out_pos_5_o),
    .move_time_o   (move_time_o),
    .mode_o        (mode_o),
    .group_total_o (group_total_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic servo_cmd_t with_frame(input servo_cmd_t cmd,
                                            input logic [GID_W-1:0] g,
                                            input logic [6:0] f);
    cmd.drive = 1'b1;
    for (int s = 0; s < POS_PORTS; s++) begin
      cmd.pos[s] = (f < NUM_FRAMES) ? kf_pos[g][f[5:0]][s] : '0;
    end
    cmd.mtime = (f < NUM_FRAMES) ? kf_time[g][f[5:0]] : '0;
    return cmd;
  endfunction

  // applies one operation to the predictor state and returns the servo command
  function automatic servo_cmd_t step_sequencer(input seq_op_t op);
    servo_cmd_t       cmd;
    logic [GID_W-1:0] g;
    logic             pass_done;
    logic [TIME_W-1:0] frame_ms;
    cmd = '0;
    case (op.func)
      FN_TICK: begin
        if (cur_mode == MODE_PLAY) begin
          g = play_grp;
          if (elapsed != '1) elapsed = elapsed + 1'b1;
          frame_ms = (cur_frame < NUM_FRAMES) ? kf_time[g][cur_frame[5:0]] : '0;
          if (elapsed >= frame_ms) begin
            cur_frame = cur_frame + 1'b1;
            pass_done = 1'b0;
            if (cur_frame >= grp_frames[g]) begin
              if (passes_left == '0) begin
                cur_frame = '0;
              end else if (passes_left > 1) begin
                passes_left = passes_left - 1'b1;
                cur_frame = '0;
              end else begin
                cur_mode = MODE_IDLE;
                pass_done = 1'b1;
              end
            end
            if (!pass_done) begin
              cmd = with_frame(cmd, g, cur_frame);
              elapsed = '0;
            end
          end
        end
      end
      FN_PLAY: begin
        if (grp_frames[op.gid] == '0) begin
          cmd.status = 1'b1;
        end else begin
          cmd.stop = (cur_mode == MODE_PLAY);
          play_grp = op.gid;
          cur_frame = '0;
          passes_left = grp_loops[op.gid];
          cur_mode = MODE_PLAY;
          elapsed = '0;
          cmd = with_frame(cmd, op.gid, 7'd0);
        end
      end
      FN_STOP: begin
        cur_mode = MODE_STOP;
        cmd.stop = 1'b1;
      end
      FN_REC_START: begin
        grp_frames[op.gid] = '0;
        grp_loops[op.gid] = op.loops;
        rec_grp = op.gid;
        cur_frame = '0;
        cur_mode = MODE_REC;
      end
      FN_REC_FRAME: begin
        if (cur_mode != MODE_REC || cur_frame >= NUM_FRAMES) begin
          cmd.status = 1'b1;
        end else begin
          for (int s = 0; s < POS_PORTS; s++) begin
            kf_pos[rec_grp][cur_frame[5:0]][s] = op.pos[s];
          end
          kf_time[rec_grp][cur_frame[5:0]] = move_time_reg;
          cur_frame = cur_frame + 1'b1;
          grp_frames[rec_grp] = cur_frame;
        end
      end
      FN_SAVE: begin
        if (cur_mode != MODE_REC || grp_frames[rec_grp] == '0) begin
          cmd.status = 1'b1;
        end else begin
          if (TOTAL_W'(rec_grp) >= saved_groups) saved_groups = TOTAL_W'(rec_grp) + 1'b1;
          cur_mode = MODE_IDLE;
        end
      end
      FN_DELETE: begin
        grp_frames[op.gid] = '0;
        grp_loops[op.gid] = 16'd1;
        if (TOTAL_W'(op.gid) < saved_groups) saved_groups = saved_groups - 1'b1;
      end
      default: begin
        cmd.status = 1'b1;
      end
    endcase
    cmd.mode = cur_mode;
    cmd.total = saved_groups;
    return cmd;
  endfunction

  function automatic seq_op_t random_op();
    seq_op_t op;
    op.func = FUNC_W'($urandom_range(0, 7));
    op.gid = GID_W'($urandom_range(0, NUM_GROUPS - 1));
    op.loops = LOOP_W'($urandom_range(0, 65535));
    for (int s = 0; s < POS_PORTS; s++) op.pos[s] = POS_W'($urandom_range(0, 4095));
    return op;
  endfunction

  function automatic logic [GID_W-1:0] rand_gid();
    return GID_W'($urandom_range(0, NUM_GROUPS - 1));
  endfunction

  function automatic logic [LOOP_W-1:0] rand_loops();
    return LOOP_W'($urandom_range(0, 65535));
  endfunction

  task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
                                 input logic [TIME_W-1:0] want);
    if (mismatches < PRINT_LIMIT) begin
      $display("tb: mismatch on %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    end
    mismatches++;
  endtask

  // one transaction on the input channel, predicted at the edge it is taken
  task automatic send_op(input seq_op_t op);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    func_i       <= op.func;
    group_id_i   <= op.gid;
    loop_count_i <= op.loops;
    pos_0_i      <= op.pos[0];
    pos_1_i      <= op.pos[1];
    pos_2_i      <= op.pos[2];
    pos_3_i      <= op.pos[3];
    pos_4_i      <= op.pos[4];
    pos_5_i      <= op.pos[5];
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pending_cmds.push_back(step_sequencer(op));
    ops_sent++;
  endtask

  task automatic send_cmd(input logic [FUNC_W-1:0] func, input logic [GID_W-1:0] gid,
                          input logic [LOOP_W-1:0] loops);
    seq_op_t op;
    op = random_op();
    op.func = func;
    op.gid = gid;
    op.loops = loops;
    send_op(op);
  endtask

  task automatic record_frame(input logic [POS_PORTS-1:0][POS_W-1:0] pos);
    seq_op_t op;
    op = random_op();
    op.func = FN_REC_FRAME;
    op.pos = pos;
    send_op(op);
  endtask

  task automatic finish_pending();
    in_valid_i <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_move_time(input logic [TIME_W-1:0] value);
    finish_pending();
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    move_time_reg = value;
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_idle_refusals();
    send_cmd(FN_TICK, 4'd0, 16'd0);
    send_cmd(FN_PLAY, 4'd15, 16'd0);
    send_cmd(FN_REC_FRAME, 4'd0, 16'd0);
    send_cmd(FN_SAVE, 4'd0, 16'd0);
    send_cmd(FN_UNUSED, 4'd7, 16'hFFFF);
    send_cmd(FN_DELETE, 4'd15, 16'd0);
    send_cmd(FN_STOP, 4'd0, 16'd0);
  endtask

  // frame stamped with the move time left by reset
  task automatic test_default_move_time();
    send_cmd(FN_REC_START, 4'd15, 16'd1);
    record_frame({POS_PORTS{12'hFFF}});
    send_cmd(FN_SAVE, 4'd0, 16'd0);
    send_cmd(FN_PLAY, 4'd15, 16'd0);
    send_cmd(FN_TICK, 4'd0, 16'd0);
    send_cmd(FN_STOP, 4'd0, 16'd0);
  endtask

  task automatic test_playback_passes();
    write_move_time(16'd1);
    send_cmd(FN_REC_START, 4'd0, 16'd2);
    record_frame('0);
    record_frame({POS_PORTS{12'hA5A}});
    send_cmd(FN_SAVE, 4'd0, 16'd0);
    send_cmd(FN_PLAY, 4'd0, 16'd0);
    // two passes of two frames, then the player goes idle
    repeat (4) send_cmd(FN_TICK, 4'd0, 16'd0);
    send_cmd(FN_PLAY, 4'd0, 16'd0);
    send_cmd(FN_PLAY, 4'd0, 16'd0);
    // deleted while playing: runs out the current frame
    send_cmd(FN_DELETE, 4'd0, 16'd0);
    repeat (2) send_cmd(FN_TICK, 4'd0, 16'd0);
    send_cmd(FN_REC_START, 4'd1, 16'd0);
    send_cmd(FN_SAVE, 4'd0, 16'd0);
    send_cmd(FN_STOP, 4'd0, 16'd0);
  endtask

  task automatic test_random_sessions();
    int unsigned                     target;
    int unsigned                     sessions;
    int unsigned                     pick;
    int unsigned                     nframes;
    int unsigned                     ticks;
    logic [GID_W-1:0]                g;
    logic [LOOP_W-1:0]               lc;
    logic [TIME_W-1:0]               mt;
    logic [POS_PORTS-1:0][POS_W-1:0] pos;
    seq_op_t                         rnd;
    target = ops_sent + RANDOM_OPS;
    sessions = 0;
    while (ops_sent < target) begin
      if (sessions % 8 == 0) begin
        case ((sessions / 8) % 6)
          0: mt = '0;
          1: mt = '1;
          2: mt = 16'd1;
          3: mt = 16'd2;
          4: mt = TIME_W'($urandom_range(0, 4));
          default: mt = TIME_W'($urandom_range(0, 65535));
        endcase
        write_move_time(mt);
      end
      if (sessions % 10 == 0) quiet = ($urandom_range(0, 3) == 0);

      // record a group
      g = GID_W'($urandom_range(0, NUM_GROUPS - 1));
      case ($urandom_range(0, 5))
        0: lc = '0;
        1: lc = 16'd1;
        2: lc = 16'd2;
        3: lc = 16'd3;
        4: lc = '1;
        default: lc = LOOP_W'($urandom_range(0, 65535));
      endcase
      pick = $urandom_range(0, 19);
      // now and then run past a full group
      nframes = (pick == 0) ? $urandom_range(NUM_FRAMES, NUM_FRAMES + 2) :
                (pick == 1) ? 0 : $urandom_range(1, 5);
      send_cmd(FN_REC_START, g, lc);
      for (int n = 0; n < nframes; n++) begin
        rnd = random_op();
        pos = rnd.pos;
        if ($urandom_range(0, 9) == 0) pos = $urandom_range(0, 1) ? '1 : '0;
        record_frame(pos);
      end
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        send_cmd(FN_SAVE, rand_gid(), rand_loops());
      end else if (pick == 8) begin
        send_cmd(FN_STOP, rand_gid(), rand_loops());
      end

      // play it back, with commands mixed into the tick stream
      if ($urandom_range(0, 4) != 0) begin
        send_cmd(FN_PLAY, ($urandom_range(0, 4) == 0) ? rand_gid() : g,
                 rand_loops());
        ticks = $urandom_range(0, 30);
        for (int n = 0; n < ticks; n++) begin
          pick = $urandom_range(0, 39);
          if (pick == 0) send_op(random_op());
          else if (pick == 1) send_cmd(FN_DELETE, g, rand_loops());
          else if (pick == 2) send_cmd(FN_PLAY, g, rand_loops());
          else if (pick == 3) send_cmd(FN_STOP, rand_gid(), rand_loops());
          else send_cmd(FN_TICK, rand_gid(), rand_loops());
        end
      end else begin
        repeat ($urandom_range(1, 3)) send_op(random_op());
      end
      sessions++;
    end
    quiet = 1'b0;
  endtask

  // receiver: holds off each result for a random number of cycles
  initial begin
    int unsigned hold;
    out_stall_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 5);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  // compare each accepted result with the oldest expected command
  always @(posedge clk_i) begin
    servo_cmd_t got;
    servo_cmd_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.status = status_o;
      got.drive  = drive_valid_o;
      got.stop   = stop_servos_o;
      got.pos    = {out_pos_5_o, out_pos_4_o, out_pos_3_o,
                    out_pos_2_o, out_pos_1_o, out_pos_0_o};
      got.mtime  = move_time_o;
      got.mode   = mode_o;
      got.total  = group_total_o;
      if (pending_cmds.size() == 0) begin
        report_mismatch("result with no transaction pending", 16'd1, 16'd0);
      end else begin
        want = pending_cmds.pop_front();
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.drive !== want.drive) report_mismatch("drive_valid", got.drive, want.drive);
        if (got.stop !== want.stop) report_mismatch("stop_servos", got.stop, want.stop);
        for (int s = 0; s < POS_PORTS; s++) begin
          if (got.pos[s] !== want.pos[s]) begin
            report_mismatch($sformatf("out_pos_%0d", s), got.pos[s], want.pos[s]);
          end
        end
        if (got.mtime !== want.mtime) report_mismatch("move_time", got.mtime, want.mtime);
        if (got.mode !== want.mode) report_mismatch("mode", got.mode, want.mode);
        if (got.total !== want.total) report_mismatch("group_total", got.total, want.total);
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= '0;
    in_valid_i   <= 1'b0;
    func_i       <= '0;
    group_id_i   <= '0;
    loop_count_i <= '0;
    pos_0_i      <= '0;
    pos_1_i      <= '0;
    pos_2_i      <= '0;
    pos_3_i      <= '0;
    pos_4_i      <= '0;
    pos_5_i      <= '0;
    quiet        = 1'b0;
    mismatches   = 0;
    ops_sent     = 0;
    idle_cycles  = 0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_frames[g] = '0;
      grp_loops[g]  = 16'd1;
      for (int f = 0; f < NUM_FRAMES; f++) begin
        kf_time[g][f] = '0;
        for (int s = 0; s < POS_PORTS; s++) kf_pos[g][f][s] = '0;
      end
    end
    cur_mode      = MODE_IDLE;
    play_grp      = '0;
    cur_frame     = '0;
    passes_left   = '0;
    elapsed       = '0;
    rec_grp       = '0;
    saved_groups  = '0;
    move_time_reg = DEF_MOVE_TIME;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_idle_refusals();
    test_default_move_time();
    test_playback_passes();
    test_random_sessions();
    finish_pending();

    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
